FILE: rtl/core/move_toward_target_step_defines.svh
// Assertion macros for the move-toward-target step block.
`ifndef MOVE_TOWARD_TARGET_STEP_DEFINES_SVH
`define MOVE_TOWARD_TARGET_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define MTS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("move step: assertion failed");
`define MTS_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) pre |=> post) \
      else $error("move step: assertion failed");
`else
`define MTS_ASSERT(lbl, prop)
`define MTS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/core/mts_pkg.sv
package mts_pkg;

   localparam int OUT_W          = 24;
   localparam int SPEED_W        = 16;
   localparam int RATE_W         = 10;
   localparam int SUB_SCALE_DEF  = 256;
   localparam int COORD_BITS_DEF = 24;

   localparam logic [RATE_W-1:0] DEFAULT_TICK_RATE = RATE_W'(20);

endpackage

FILE: rtl/core/move_toward_target_step.sv
// Move-toward-target step: one moving point per transfer on the req_ channel
// (current position, goal position, speed), one result per item on the rsp_
// channel (new position and an arrived flag). Items are independent.
// csr_wr_en/csr_wr_data set the tick rate (ticks per second); zero means 20.
// Write it only while no item is in flight.
// Stages: 3 front stages, max(COORD_BITS+1, 16+clog2(SUB_SCALE+1)) stages of
// square root and step division side by side, one compare stage, one multiply
// stage, COORD_BITS stages of restoring division and the output register.
// Throughput is one item per cycle while the receiver takes results; each
// stage does one root bit and one quotient bit, so the depth follows the
// widths of root and quotients.
// The pipeline moves as one whole: it advances when the output register is
// empty or being taken. While the receiver stalls with a result waiting,
// req_ready is low and every stage holds; nothing is lost or repeated.
// Synchronous reset clears all valid bits and sets the tick rate to 20.
`include "move_toward_target_step_defines.svh"

module move_toward_target_step #(
   parameter int SUB_SCALE  = mts_pkg::SUB_SCALE_DEF,
   parameter int COORD_BITS = mts_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [COORD_BITS-1:0]          req_cur_x,
   input  logic [COORD_BITS-1:0]          req_cur_y,
   input  logic [COORD_BITS-1:0]          req_goal_x,
   input  logic [COORD_BITS-1:0]          req_goal_y,
   input  logic [mts_pkg::SPEED_W-1:0]    req_speed,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mts_pkg::OUT_W-1:0]      rsp_new_x,
   output logic [mts_pkg::OUT_W-1:0]      rsp_new_y,
   output logic                           rsp_arrived,
   input  logic                           csr_wr_en,
   input  logic [mts_pkg::RATE_W-1:0]     csr_wr_data
);

   localparam int CB  = COORD_BITS;
   localparam int RW  = CB + 1;
   localparam int DW  = 2 * RW;
   localparam int SW  = mts_pkg::SPEED_W + $clog2(SUB_SCALE + 1);
   localparam int RTW = mts_pkg::RATE_W;
   localparam int NL  = (RW > SW) ? RW : SW;
   localparam int NF  = 3 + NL;
   localparam int PW  = CB + RW;
   localparam int MW  = (RW > SW) ? RW : SW;

   typedef struct packed {
      logic [CB-1:0]   cx;
      logic [CB-1:0]   cy;
      logic [CB-1:0]   gx;
      logic [CB-1:0]   gy;
      logic            neg_x;
      logic            neg_y;
      logic [CB-1:0]   ax;
      logic [CB-1:0]   ay;
      logic [2*CB-1:0] sqx;
      logic [2*CB-1:0] sqy;
      logic [DW-1:0]   sq_v;
      logic [RW+1:0]   sq_r;
      logic [RW-1:0]   sq_q;
      logic [SW-1:0]   dv_nq;
      logic [RTW:0]    dv_r;
      logic [RTW-1:0]  rate;
   } front_type;

   typedef struct packed {
      logic [CB-1:0] cx;
      logic [CB-1:0] cy;
      logic [CB-1:0] gx;
      logic [CB-1:0] gy;
      logic          neg_x;
      logic          neg_y;
      logic [CB-1:0] ax;
      logic [CB-1:0] ay;
      logic [RW-1:0] d;
      logic [RW-1:0] step;
      logic          arr;
   } cmp_type;

   typedef struct packed {
      logic [CB-1:0] cx;
      logic [CB-1:0] cy;
      logic [CB-1:0] gx;
      logic [CB-1:0] gy;
      logic          neg_x;
      logic          neg_y;
      logic [CB-1:0] ax;
      logic [CB-1:0] ay;
      logic [RW-1:0] d;
      logic [PW-1:0] px;
      logic [PW-1:0] py;
      logic          arr;
   } mul_type;

   typedef struct packed {
      logic [CB-1:0] cx;
      logic [CB-1:0] cy;
      logic [CB-1:0] gx;
      logic [CB-1:0] gy;
      logic          neg_x;
      logic          neg_y;
      logic [CB-1:0] ax;
      logic [CB-1:0] ay;
      logic [RW-1:0] d;
      logic [RW-1:0] r_x;
      logic [RW-1:0] r_y;
      logic [CB-1:0] nq_x;
      logic [CB-1:0] nq_y;
      logic          arr;
   } div_type;

   logic [RTW-1:0] tick_rate_ff;
   logic           adv;

   front_type front_in [NF];
   front_type front_ff [NF];
   logic      fv_ff    [NF];
   cmp_type   cmp_in, cmp_ff;
   logic      cv_ff;
   mul_type   mul_in, mul_ff;
   logic      mv_ff;
   div_type   seed;
   div_type   div_in [CB];
   div_type   div_ff [CB];
   logic      dv_ff  [CB];
   logic [mts_pkg::OUT_W-1:0] new_x_in, new_y_in, new_x_ff, new_y_ff;
   logic      arr_in, arr_ff, ov_ff;

   // whole pipeline moves together; hold everything while a result waits
   assign adv       = !ov_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= mts_pkg::DEFAULT_TICK_RATE;
      end else if (csr_wr_en) begin
         tick_rate_ff <= csr_wr_data;
      end
   end

   // front stage 0: differences, rate fix-up, step numerator
   always_comb begin
      front_in[0]       = '0;
      front_in[0].cx    = req_cur_x;
      front_in[0].cy    = req_cur_y;
      front_in[0].gx    = req_goal_x;
      front_in[0].gy    = req_goal_y;
      front_in[0].neg_x = req_goal_x < req_cur_x;
      front_in[0].neg_y = req_goal_y < req_cur_y;
      front_in[0].ax    = (req_goal_x < req_cur_x) ? req_cur_x - req_goal_x
                                                   : req_goal_x - req_cur_x;
      front_in[0].ay    = (req_goal_y < req_cur_y) ? req_cur_y - req_goal_y
                                                   : req_goal_y - req_cur_y;
      front_in[0].rate  = (tick_rate_ff == '0) ? mts_pkg::DEFAULT_TICK_RATE
                                               : tick_rate_ff;
      front_in[0].dv_nq = SW'(req_speed) * SW'(SUB_SCALE);
   end

   // front stage 1: squares
   always_comb begin
      front_in[1]     = front_ff[0];
      front_in[1].sqx = (2*CB)'(front_ff[0].ax) * (2*CB)'(front_ff[0].ax);
      front_in[1].sqy = (2*CB)'(front_ff[0].ay) * (2*CB)'(front_ff[0].ay);
   end

   // front stage 2: squared distance
   always_comb begin
      front_in[2]      = front_ff[1];
      front_in[2].sq_v = DW'(front_ff[1].sqx) + DW'(front_ff[1].sqy);
   end

   // one root bit and one step quotient bit per stage
   for (genvar k = 3; k < NF; k++) begin : g_root
      logic [RW+1:0] sr_n, sr_t;
      logic [RTW:0]  dr_n;

      assign sr_n = {front_ff[k-1].sq_r[RW-1:0], front_ff[k-1].sq_v[DW-1 -: 2]};
      assign sr_t = {front_ff[k-1].sq_q, 2'b01};
      assign dr_n = {front_ff[k-1].dv_r[RTW-1:0], front_ff[k-1].dv_nq[SW-1]};

      always_comb begin
         front_in[k] = front_ff[k-1];
         if (k - 3 < RW) begin
            front_in[k].sq_v = front_ff[k-1].sq_v << 2;
            if (sr_n >= sr_t) begin
               front_in[k].sq_r = sr_n - sr_t;
               front_in[k].sq_q = {front_ff[k-1].sq_q[RW-2:0], 1'b1};
            end else begin
               front_in[k].sq_r = sr_n;
               front_in[k].sq_q = {front_ff[k-1].sq_q[RW-2:0], 1'b0};
            end
         end
         if (k - 3 < SW) begin
            if (dr_n >= {1'b0, front_ff[k-1].rate}) begin
               front_in[k].dv_r  = dr_n - {1'b0, front_ff[k-1].rate};
               front_in[k].dv_nq = {front_ff[k-1].dv_nq[SW-2:0], 1'b1};
            end else begin
               front_in[k].dv_r  = dr_n;
               front_in[k].dv_nq = {front_ff[k-1].dv_nq[SW-2:0], 1'b0};
            end
         end
      end
   end

   // arrive when dist2 <= step^2, decided from the root and its remainder
   always_comb begin
      cmp_in.cx    = front_ff[NF-1].cx;
      cmp_in.cy    = front_ff[NF-1].cy;
      cmp_in.gx    = front_ff[NF-1].gx;
      cmp_in.gy    = front_ff[NF-1].gy;
      cmp_in.neg_x = front_ff[NF-1].neg_x;
      cmp_in.neg_y = front_ff[NF-1].neg_y;
      cmp_in.ax    = front_ff[NF-1].ax;
      cmp_in.ay    = front_ff[NF-1].ay;
      cmp_in.d     = front_ff[NF-1].sq_q;
      cmp_in.step  = RW'(front_ff[NF-1].dv_nq);
      cmp_in.arr   = (MW'(front_ff[NF-1].sq_q) < MW'(front_ff[NF-1].dv_nq)) ||
                     ((MW'(front_ff[NF-1].sq_q) == MW'(front_ff[NF-1].dv_nq)) &&
                      (front_ff[NF-1].sq_r == '0));
   end

   always_comb begin
      mul_in.cx    = cmp_ff.cx;
      mul_in.cy    = cmp_ff.cy;
      mul_in.gx    = cmp_ff.gx;
      mul_in.gy    = cmp_ff.gy;
      mul_in.neg_x = cmp_ff.neg_x;
      mul_in.neg_y = cmp_ff.neg_y;
      mul_in.ax    = cmp_ff.ax;
      mul_in.ay    = cmp_ff.ay;
      mul_in.d     = cmp_ff.d;
      mul_in.arr   = cmp_ff.arr;
      mul_in.px    = PW'(cmp_ff.ax) * PW'(cmp_ff.step);
      mul_in.py    = PW'(cmp_ff.ay) * PW'(cmp_ff.step);
   end

   // high part of the product is already below d
   always_comb begin
      seed.cx    = mul_ff.cx;
      seed.cy    = mul_ff.cy;
      seed.gx    = mul_ff.gx;
      seed.gy    = mul_ff.gy;
      seed.neg_x = mul_ff.neg_x;
      seed.neg_y = mul_ff.neg_y;
      seed.ax    = mul_ff.ax;
      seed.ay    = mul_ff.ay;
      seed.d     = mul_ff.d;
      seed.arr   = mul_ff.arr;
      seed.r_x   = mul_ff.px[PW-1:CB];
      seed.r_y   = mul_ff.py[PW-1:CB];
      seed.nq_x  = mul_ff.px[CB-1:0];
      seed.nq_y  = mul_ff.py[CB-1:0];
   end

   for (genvar j = 0; j < CB; j++) begin : g_div
      div_type prv;
      logic [RW:0] rx_n, ry_n;

      if (j == 0) begin : g_first
         assign prv = seed;
      end else begin : g_rest
         assign prv = div_ff[j-1];
      end

      assign rx_n = {prv.r_x, prv.nq_x[CB-1]};
      assign ry_n = {prv.r_y, prv.nq_y[CB-1]};

      always_comb begin
         div_in[j] = prv;
         if (rx_n >= {1'b0, prv.d}) begin
            div_in[j].r_x  = RW'(rx_n - {1'b0, prv.d});
            div_in[j].nq_x = {prv.nq_x[CB-2:0], 1'b1};
         end else begin
            div_in[j].r_x  = RW'(rx_n);
            div_in[j].nq_x = {prv.nq_x[CB-2:0], 1'b0};
         end
         if (ry_n >= {1'b0, prv.d}) begin
            div_in[j].r_y  = RW'(ry_n - {1'b0, prv.d});
            div_in[j].nq_y = {prv.nq_y[CB-2:0], 1'b1};
         end else begin
            div_in[j].r_y  = RW'(ry_n);
            div_in[j].nq_y = {prv.nq_y[CB-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (div_ff[CB-1].arr) begin
         new_x_in = mts_pkg::OUT_W'(div_ff[CB-1].gx);
         new_y_in = mts_pkg::OUT_W'(div_ff[CB-1].gy);
      end else begin
         new_x_in = div_ff[CB-1].neg_x
                    ? mts_pkg::OUT_W'(div_ff[CB-1].cx - div_ff[CB-1].nq_x)
                    : mts_pkg::OUT_W'(div_ff[CB-1].cx + div_ff[CB-1].nq_x);
         new_y_in = div_ff[CB-1].neg_y
                    ? mts_pkg::OUT_W'(div_ff[CB-1].cy - div_ff[CB-1].nq_y)
                    : mts_pkg::OUT_W'(div_ff[CB-1].cy + div_ff[CB-1].nq_y);
      end
      arr_in = div_ff[CB-1].arr;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NF; i++) begin
            front_ff[i] <= front_in[i];
         end
         cmp_ff <= cmp_in;
         mul_ff <= mul_in;
         for (int i = 0; i < CB; i++) begin
            div_ff[i] <= div_in[i];
         end
         new_x_ff <= new_x_in;
         new_y_ff <= new_y_in;
         arr_ff   <= arr_in;
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NF; i++) begin
            fv_ff[i] <= 1'b0;
         end
         cv_ff <= 1'b0;
         mv_ff <= 1'b0;
         for (int i = 0; i < CB; i++) begin
            dv_ff[i] <= 1'b0;
         end
         ov_ff <= 1'b0;
      end else if (adv) begin
         fv_ff[0] <= req_valid;
         for (int i = 1; i < NF; i++) begin
            fv_ff[i] <= fv_ff[i-1];
         end
         cv_ff    <= fv_ff[NF-1];
         mv_ff    <= cv_ff;
         dv_ff[0] <= mv_ff;
         for (int i = 1; i < CB; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
         ov_ff <= dv_ff[CB-1];
      end
   end

   assign rsp_valid   = ov_ff;
   assign rsp_new_x   = new_x_ff;
   assign rsp_new_y   = new_y_ff;
   assign rsp_arrived = arr_ff;

   `MTS_ASSERT_NEXT(a_enter, req_valid && req_ready, fv_ff[0])
   `MTS_ASSERT(a_step_rem, fv_ff[NF-1] |-> front_ff[NF-1].dv_r < (RTW+1)'(front_ff[NF-1].rate))
   `MTS_ASSERT(a_root_nz, cv_ff && !cmp_ff.arr |-> cmp_ff.d != '0)
   `MTS_ASSERT(a_step_x, dv_ff[CB-1] && !div_ff[CB-1].arr |-> div_ff[CB-1].nq_x <= div_ff[CB-1].ax)
   `MTS_ASSERT(a_step_y, dv_ff[CB-1] && !div_ff[CB-1].arr |-> div_ff[CB-1].nq_y <= div_ff[CB-1].ay)

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

class move_scoreboard;
   typedef struct {
      logic [23:0] nx;
      logic [23:0] ny;
      logic        arr;
   } pos_type;

   pos_type     pending_pos[$];
   logic [9:0]  tick_rate;
   int          errors;

   function new();
      tick_rate = mts_pkg::DEFAULT_TICK_RATE;
      errors = 0;
   endfunction

   function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function logic [23:0] nudge(longint unsigned c, longint unsigned g,
                               longint unsigned s, longint unsigned d);
      if (g >= c) return 24'((c + ((g - c) * s) / d));
      return 24'((c - ((c - g) * s) / d));
   endfunction

   // work out the next position for one accepted point
   function void note_point(logic [23:0] cx, logic [23:0] cy, logic [23:0] gx,
                            logic [23:0] gy, logic [15:0] spd);
      longint unsigned rate, s, ax, ay, d2, d;
      pos_type p;
      rate = (tick_rate == 0) ? 20 : tick_rate;
      s = (longint'(spd) * 256) / rate;
      ax = (gx >= cx) ? gx - cx : cx - gx;
      ay = (gy >= cy) ? gy - cy : cy - gy;
      d2 = ax * ax + ay * ay;
      if (d2 <= s * s) begin
         p.nx = gx; p.ny = gy; p.arr = 1'b1;
      end else begin
         d = isqrt(d2);
         if (d == 0) d = 1;
         p.nx = nudge(cx, gx, s, d);
         p.ny = nudge(cy, gy, s, d);
         p.arr = 1'b0;
      end
      pending_pos = {pending_pos, p};
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task check_pos(logic [23:0] nx, logic [23:0] ny, logic arr);
      pos_type p;
      if (pending_pos.size() == 0) begin
         report("result with nothing expected");
         return;
      end
      p = pending_pos.pop_front();
      if (nx !== p.nx) report($sformatf("new_x %h want %h", nx, p.nx));
      if (ny !== p.ny) report($sformatf("new_y %h want %h", ny, p.ny));
      if (arr !== p.arr) report($sformatf("arrived %b want %b", arr, p.arr));
   endtask
endclass

module testbench;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [23:0] req_cur_x = '0, req_cur_y = '0, req_goal_x = '0, req_goal_y = '0;
   logic [15:0] req_speed = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_new_x, rsp_new_y;
   logic        rsp_arrived;
   logic        csr_wr_en = 1'b0;
   logic [9:0]  csr_wr_data = '0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   move_scoreboard sb = new();

   move_toward_target_step u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sample results at the rising edge, change ready at the falling one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_pos(rsp_new_x, rsp_new_y, rsp_arrived);
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // valid stays high after a transfer until the next item or an idle cycle
   task send_point(logic [23:0] cx, logic [23:0] cy, logic [23:0] gx,
                   logic [23:0] gy, logic [15:0] spd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cur_x <= cx; req_cur_y <= cy;
      req_goal_x <= gx; req_goal_y <= gy;
      req_speed <= spd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_point(cx, cy, gx, gy, spd);
      @(negedge clock);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.pending_pos.size() != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   task set_rate(logic [9:0] r);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= r;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.tick_rate = r;
   endtask

   task random_point();
      logic [23:0] cx, cy, gx, gy;
      logic [15:0] spd;
      int span;
      cx = 24'($urandom); cy = 24'($urandom);
      span = $urandom_range(3);
      // mostly nearby goals so that arrival and movement both occur
      case (span)
         0: begin gx = 24'($urandom); gy = 24'($urandom); end
         1: begin
            gx = 24'(cx + $urandom_range(4000) - 2000);
            gy = 24'(cy + $urandom_range(4000) - 2000);
         end
         2: begin
            gx = 24'(cx + $urandom_range(200000) - 100000);
            gy = 24'(cy + $urandom_range(200000) - 100000);
         end
         default: begin gx = cx; gy = 24'(cy + $urandom_range(300) - 150); end
      endcase
      spd = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
      if ($urandom_range(3) == 0) spd = 16'($urandom_range(200));
      send_point(cx, cy, gx, gy, spd);
   endtask

   initial begin
      int ph;
      logic [9:0] rates[6] = '{10'd20, 10'd1, 10'd1023, 10'd0, 10'd1000, 10'd7};
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, zero speed, exact arrival, opposite corners
      send_point(24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
      send_point(24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 16'd1);
      send_point(24'd100, 24'd200, 24'd100, 24'd200, 16'd0);
      send_point(24'd100, 24'd200, 24'd101, 24'd200, 16'd0);
      send_point(24'hFFFFFF, 24'd0, 24'd0, 24'hFFFFFF, 16'd0);
      send_point(24'd0, 24'd0, 24'd12, 24'd0, 16'd1);
      send_point(24'd0, 24'd0, 24'd13, 24'd0, 16'd1);
      send_point(24'd5000, 24'd5000, 24'd0, 24'd0, 16'd100);
      send_point(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'h8000);
      for (ph = 0; ph < 6; ph++) begin
         set_rate(rates[ph]);
         send_point(24'd0, 24'd0, 24'd3000, 24'd4000, 16'd50);
         send_point(24'hFFFFFF, 24'd0, 24'd0, 24'hFFFFFF, 16'hFFFF);
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 76; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 76; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         repeat (170) random_point();
         send_idle_pct = 0; stall_pct = 0;
      end
      drain();
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/mts_pkg.sv
rtl/core/move_toward_target_step.sv
dv/testbench.sv
